/* rtl/sa_focus_delay_calc_top_macros.svh */
// Assertion macros shared by the focusing-delay RTL.
`ifndef SA_FOCUS_DELAY_CALC_TOP_MACROS_SVH
`define SA_FOCUS_DELAY_CALC_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/sa_fdc_pkg.sv */
// Shared widths, register codes and control types of the focusing-delay block.
`timescale 1ns / 1ps
package sa_fdc_pkg;
    localparam int DVD_W = 62;   // rounded parabolic numerator
    localparam int DVS_W = 29;   // focal depth, um Q8
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_FOCUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_FOCUS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPU      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST    = 3'd7;

    typedef struct packed {
        logic en;    // whole pipe advances
        logic vld;   // item present at the divider input
    } t_stage_ctl;
endpackage

/* rtl/sa_fdc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module sa_fdc_div #(
    parameter int SIDE_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sa_fdc_pkg::t_stage_ctl       i_ctl,
    input  logic [sa_fdc_pkg::DVD_W-1:0] i_dividend,
    input  logic [sa_fdc_pkg::DVS_W-1:0] i_divisor,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_vld,
    output logic [sa_fdc_pkg::DVD_W-1:0] o_quot,
    output logic [SIDE_W-1:0]            o_side
);
    localparam int NW = sa_fdc_pkg::DVD_W;
    localparam int DW = sa_fdc_pkg::DVS_W;

    logic [NW-1:0] r_v;
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_dvd  [NW];
    logic [NW-1:0] r_q    [NW];
    logic [DW-1:0] r_d    [NW];
    logic [SIDE_W-1:0] r_side [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_dvd;
        logic [NW-1:0] p_q;
        logic [DW-1:0] p_d;
        logic [SIDE_W-1:0] p_side;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (g == 0) begin : g_first
            assign p_v    = i_ctl.vld;
            assign p_rem  = '0;
            assign p_dvd  = i_dividend;
            assign p_q    = '0;
            assign p_d    = i_divisor;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_dvd  = r_dvd[g-1];
            assign p_q    = r_q[g-1];
            assign p_d    = r_d[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            trial = {p_rem, p_dvd[NW-1]};
            diff  = trial - {1'b0, p_d};
            ge    = (trial >= {1'b0, p_d});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[g]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_dvd[g]  <= {p_dvd[NW-2:0], 1'b0};
                r_q[g]    <= {p_q[NW-2:0], ge};
                r_d[g]    <= p_d;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_v[NW-1];
    assign o_quot = r_q[NW-1];
    assign o_side = r_side[NW-1];
endmodule

/* rtl/sa_focus_delay_calc_top.sv */
// Focusing-delay generator: round-trip path to saturated raw sample index.
// Throughput: one item per cycle while results are accepted; every stage, divider included, is fully pipelined.
// The whole pipe halts while a result waits unaccepted at the output.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
`include "sa_focus_delay_calc_top_macros.svh"
module sa_focus_delay_calc_top #(
    parameter int ELEMENTS      = 128,
    parameter int DEPTH_INDICES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tx_element[6:0] rx_element[13:7] depth_index[25:14] sin_tx_angle[41:26]
    // sin_rx_angle[57:42] tx_correction[73:58] rx_correction[89:74], zero pad
    input  logic [95:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // sample_whole[15:0] sample_fraction[23:16]
    output logic [23:0] o_m_axis_tdata,
    // saturated[0]
    output logic        o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [sa_fdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sa_fdc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int NW = sa_fdc_pkg::DVD_W;
    localparam int DW = sa_fdc_pkg::DVS_W;
    localparam int MOD_S = 24;
    localparam longint MOD_R = ((64'd1 << MOD_S) + DEPTH_INDICES - 1) / DEPTH_INDICES;
    localparam bit MOD_BYPASS = (DEPTH_INDICES >= 4096);
    localparam int SIDE_TX_W = 39 + 16 + 1;
    localparam int SIDE_RX_W = 39 + 16;

    // configuration
    logic [10:0] r_pitch;
    logic [17:0] r_start;
    logic [15:0] r_step;
    logic [2:0]  r_mode;
    logic [17:0] r_tx_focus;
    logic [17:0] r_rx_focus;
    logic [23:0] r_spu;
    logic [15:0] r_first;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch    <= 11'd300;
            r_start    <= 18'd0;
            r_step     <= 16'd9856;
            r_mode     <= 3'd1;
            r_tx_focus <= 18'd10000;
            r_rx_focus <= 18'd10000;
            r_spu      <= 24'd435700;
            r_first    <= 16'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sa_fdc_pkg::CFG_PITCH:    r_pitch    <= i_cfg_data[10:0];
                sa_fdc_pkg::CFG_START:    r_start    <= i_cfg_data[17:0];
                sa_fdc_pkg::CFG_STEP:     r_step     <= i_cfg_data[15:0];
                sa_fdc_pkg::CFG_MODE:     r_mode     <= i_cfg_data[2:0];
                sa_fdc_pkg::CFG_TX_FOCUS: r_tx_focus <= i_cfg_data[17:0];
                sa_fdc_pkg::CFG_RX_FOCUS: r_rx_focus <= i_cfg_data[17:0];
                sa_fdc_pkg::CFG_SPU:      r_spu      <= i_cfg_data;
                sa_fdc_pkg::CFG_FIRST:    r_first    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // global advance: the output register is empty or being taken
    logic r_out_v;
    logic en;
    assign en = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = en && i_rst_n;

    // element position factor 2k+1-ELEMENTS, k = element mod ELEMENTS
    logic signed [9:0] c_fac [128];
    for (genvar j = 0; j < 128; j++) begin : g_fac
        assign c_fac[j] = 10'(2 * (j % ELEMENTS) + 1 - ELEMENTS);
    end

    // stage 1: input capture
    logic        r1_v;
    logic [6:0]  r1_etx, r1_erx;
    logic [11:0] r1_idx;
    logic signed [15:0] r1_stx, r1_srx, r1_ctx, r1_crx;

    // stage 2: depth reciprocal product, position factors
    logic        r2_v;
    logic [11:0] r2_idx;
    logic [30:0] r2_qd;
    logic signed [9:0]  r2_ftx, r2_frx;
    logic signed [15:0] r2_stx, r2_srx, r2_ctx, r2_crx;

    // stage 3: depth index modulo, positions in half um
    logic        r3_v;
    logic [11:0] r3_idx;
    logic signed [20:0] r3_ptx, r3_prx;
    logic signed [15:0] r3_stx, r3_srx, r3_ctx, r3_crx;

    // stage 4: depth, squares, steering terms
    logic        r4_v;
    logic [28:0] r4_depth;
    logic [39:0] r4_sqtx, r4_sqrx;
    logic signed [35:0] r4_sttx, r4_strx;
    logic signed [15:0] r4_ctx, r4_crx;

    // stage 5: divider operands and leg bases
    logic        r5_v;
    logic [NW-1:0] r5_ntx, r5_nrx;
    logic [DW-1:0] r5_dtx, r5_drx;
    logic signed [38:0] r5_btx, r5_brx;
    logic signed [15:0] r5_ctx, r5_crx;
    logic        r5_plane;

    logic [10:0] r2_pitch_x;
    assign r2_pitch_x = r_pitch;

    logic [11:0] s2_q;
    logic [19:0] s2_qd;
    logic [11:0] s3_idx;
    logic [21:0] s3_ptx, s3_prx;
    logic [41:0] s4_sqtx, s4_sqrx;
    logic [36:0] s4_sttx, s4_strx;
    logic [28:0] s5_depth_f;
    logic [DW-1:0] s5_ftx, s5_frx;

    always_comb begin
        s2_q  = 12'(r2_qd >> MOD_S);
        s2_qd = 20'(s2_q) * 20'(DEPTH_INDICES);
        s3_idx = MOD_BYPASS ? r2_idx : 12'(20'(r2_idx) - s2_qd);
        s3_ptx = r2_ftx * $signed({1'b0, r2_pitch_x});
        s3_prx = r2_frx * $signed({1'b0, r2_pitch_x});
        s4_sqtx = r3_ptx * r3_ptx;
        s4_sqrx = r3_prx * r3_prx;
        s4_sttx = r3_ptx * r3_stx;
        s4_strx = r3_prx * r3_srx;
        s5_depth_f = (r4_depth == '0) ? 29'd1 : r4_depth;
        s5_ftx = r_mode[0] ? s5_depth_f
                 : ((r_tx_focus == '0) ? 29'd1 : {3'b0, r_tx_focus, 8'b0});
        s5_frx = r_mode[1] ? s5_depth_f
                 : ((r_rx_focus == '0) ? 29'd1 : {3'b0, r_rx_focus, 8'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_etx <= i_s_axis_tdata[6:0];
            r1_erx <= i_s_axis_tdata[13:7];
            r1_idx <= i_s_axis_tdata[25:14];
            r1_stx <= i_s_axis_tdata[41:26];
            r1_srx <= i_s_axis_tdata[57:42];
            r1_ctx <= i_s_axis_tdata[73:58];
            r1_crx <= i_s_axis_tdata[89:74];

            r2_idx <= r1_idx;
            r2_qd  <= 31'(r1_idx) * 31'(MOD_R);
            r2_ftx <= c_fac[r1_etx];
            r2_frx <= c_fac[r1_erx];
            r2_stx <= r1_stx;
            r2_srx <= r1_srx;
            r2_ctx <= r1_ctx;
            r2_crx <= r1_crx;

            r3_idx <= s3_idx;
            r3_ptx <= s3_ptx[20:0];
            r3_prx <= s3_prx[20:0];
            r3_stx <= r2_stx;
            r3_srx <= r2_srx;
            r3_ctx <= r2_ctx;
            r3_crx <= r2_crx;

            r4_depth <= {3'b0, r_start, 8'b0} + 29'(r3_idx) * 29'(r_step);
            r4_sqtx  <= s4_sqtx[39:0];
            r4_sqrx  <= s4_sqrx[39:0];
            r4_sttx  <= s4_sttx[35:0];
            r4_strx  <= s4_strx[35:0];
            r4_ctx   <= r3_ctx;
            r4_crx   <= r3_crx;

            r5_ntx   <= {1'b0, r4_sqtx, 21'b0} + NW'(s5_ftx >> 1);
            r5_nrx   <= {1'b0, r4_sqrx, 21'b0} + NW'(s5_frx >> 1);
            r5_dtx   <= s5_ftx;
            r5_drx   <= s5_frx;
            r5_btx   <= $signed({2'b0, r4_depth, 8'b0}) - 39'(r4_sttx);
            r5_brx   <= $signed({2'b0, r4_depth, 8'b0}) - 39'(r4_strx);
            r5_ctx   <= r4_ctx;
            r5_crx   <= r4_crx;
            r5_plane <= r_mode[2];
        end
    end

    // parabolic-term dividers, one per leg
    sa_fdc_pkg::t_stage_ctl div_ctl;
    assign div_ctl.en  = en;
    assign div_ctl.vld = r5_v;

    logic                 dtx_v, drx_v;
    logic [NW-1:0]        dtx_q, drx_q;
    logic [SIDE_TX_W-1:0] dtx_side;
    logic [SIDE_RX_W-1:0] drx_side;

    sa_fdc_div #(.SIDE_W(SIDE_TX_W)) u_div_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r5_ntx),
        .i_divisor  (r5_dtx),
        .i_side     ({r5_plane, r5_ctx, r5_btx}),
        .o_vld      (dtx_v),
        .o_quot     (dtx_q),
        .o_side     (dtx_side)
    );

    sa_fdc_div #(.SIDE_W(SIDE_RX_W)) u_div_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r5_nrx),
        .i_divisor  (r5_drx),
        .i_side     ({r5_crx, r5_brx}),
        .o_vld      (drx_v),
        .o_quot     (drx_q),
        .o_side     (drx_side)
    );

    logic signed [38:0] d_btx, d_brx;
    logic signed [15:0] d_ctx, d_crx;
    logic               d_plane;
    assign d_btx   = dtx_side[38:0];
    assign d_ctx   = dtx_side[54:39];
    assign d_plane = dtx_side[55];
    assign d_brx   = drx_side[38:0];
    assign d_crx   = drx_side[54:39];

    // back end
    logic        r6_v, r7_v, r8_v, r9_v, r10_v, r11_v, r12_v;
    logic signed [64:0] r6_ltx, r6_lrx;
    logic signed [65:0] r7_path;
    logic [64:0] r8_mag;
    logic        r8_neg, r9_neg, r10_neg, r11_neg, r12_neg;
    logic [52:0] r9_pl, r9_ph;
    logic        r9_big, r10_big, r11_big, r12_big;
    logic [57:0] r10_prod;
    logic signed [27:0] r11_raw;
    logic signed [29:0] r12_v_idx;
    logic signed [15:0] r6_ctx, r6_crx, r7_ctx, r7_crx, r8_ctx, r8_crx;
    logic signed [15:0] r9_ctx, r9_crx, r10_ctx, r10_crx, r11_ctx, r11_crx;
    logic signed [15:0] r_out_whole;
    logic [7:0]  r_out_frac;
    logic        r_out_sat;

    logic [81:0] s10_prod;
    logic [58:0] s11_up, s11_dn;
    logic signed [29:0] s13_v;
    logic        s13_lo, s13_hi;

    localparam logic signed [29:0] V_LO = -30'sd8388608;
    localparam logic signed [29:0] V_HI = 30'sd8388607;

    always_comb begin
        s10_prod = {r9_ph, 29'b0} + 82'(r9_pl);
        s11_up   = {1'b0, r10_prod} + 59'h0_8000_0000;
        s11_dn   = {1'b0, r10_prod} + 59'h0_7FFF_FFFF;
        s13_v    = r12_v_idx;
        s13_lo   = r12_big ? r12_neg : (s13_v < V_LO);
        s13_hi   = r12_big ? !r12_neg : (s13_v > V_HI);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r10_v   <= 1'b0;
            r11_v   <= 1'b0;
            r12_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r6_v    <= dtx_v;
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
            r10_v   <= r9_v;
            r11_v   <= r10_v;
            r12_v   <= r11_v;
            r_out_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ltx <= 65'(d_btx) + (d_plane ? 65'sd0 : $signed({3'b0, dtx_q}));
            r6_lrx <= 65'(d_brx) + (d_plane ? 65'sd0 : $signed({3'b0, drx_q}));
            r6_ctx <= d_ctx;
            r6_crx <= d_crx;

            r7_path <= 66'(r6_ltx) + 66'(r6_lrx);
            r7_ctx  <= r6_ctx;
            r7_crx  <= r6_crx;

            r8_neg <= r7_path[65];
            r8_mag <= r7_path[65] ? 65'(-r7_path) : r7_path[64:0];
            r8_ctx <= r7_ctx;
            r8_crx <= r7_crx;

            // a path this long saturates whatever the scale (zero scale aside)
            r9_big <= (r8_mag[64:58] != '0) && (r_spu != '0);
            r9_neg <= r8_neg;
            r9_pl  <= r8_mag[28:0] * r_spu;
            r9_ph  <= r8_mag[57:29] * r_spu;
            r9_ctx <= r8_ctx;
            r9_crx <= r8_crx;

            r10_big  <= r9_big || (s10_prod[81:58] != '0);
            r10_prod <= s10_prod[57:0];
            r10_neg  <= r9_neg;
            r10_ctx  <= r9_ctx;
            r10_crx  <= r9_crx;

            // nearest, ties toward plus infinity on both sides of zero
            r11_raw <= r10_neg ? -$signed({1'b0, s11_dn[58:32]})
                               :  $signed({1'b0, s11_up[58:32]});
            r11_big <= r10_big;
            r11_neg <= r10_neg;
            r11_ctx <= r10_ctx;
            r11_crx <= r10_crx;

            r12_v_idx <= 30'(r11_raw) + 30'(r11_ctx) + 30'(r11_crx)
                         - $signed({6'b0, r_first, 8'b0});
            r12_big   <= r11_big;
            r12_neg   <= r11_neg;

            priority if (s13_lo) begin
                r_out_whole <= -16'sd32768;
                r_out_frac  <= 8'd0;
                r_out_sat   <= 1'b1;
            end else if (s13_hi) begin
                r_out_whole <= 16'sd32767;
                r_out_frac  <= 8'd255;
                r_out_sat   <= 1'b1;
            end else begin
                r_out_whole <= s13_v[23:8];
                r_out_frac  <= s13_v[7:0];
                r_out_sat   <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out_frac, r_out_whole};
    assign o_m_axis_tuser  = r_out_sat;

    logic out_at_limit;
    assign out_at_limit = (r_out_whole == -16'sd32768 && r_out_frac == 8'd0)
                          || (r_out_whole == 16'sd32767 && r_out_frac == 8'd255);

    `SA_ASSERT(a_lanes_aligned, i_clk, i_rst_n, dtx_v == drx_v, "divider lanes out of step")
    `SA_ASSERT(a_sat_shape, i_clk, i_rst_n, r_out_v && r_out_sat |-> out_at_limit, "bad limit")
    `SA_ASSERT(a_stall_holds_div, i_clk, i_rst_n, !en |=> $stable(dtx_q) && $stable(dtx_v), "divider moved during stall")
endmodule
